>>> rtl/core/rrfb_pkg.sv
// shared types, constants and helper functions for the read request frame builder
// no dependencies

package rrfb_pkg;

    localparam int FRAME_LEN  = 38;
    localparam int POS_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int START_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // frame layout
    localparam logic [POS_W-1:0] POS_DONGLE   = 6'd8;
    localparam logic [POS_W-1:0] POS_LEN_LO   = 6'd18;
    localparam logic [POS_W-1:0] POS_LEN_HI   = 6'd19;
    localparam logic [POS_W-1:0] POS_ACTION   = 6'd20;
    localparam logic [POS_W-1:0] POS_FUNC     = 6'd21;
    localparam logic [POS_W-1:0] POS_SERIAL   = 6'd22;
    localparam logic [POS_W-1:0] POS_START_LO = 6'd32;
    localparam logic [POS_W-1:0] POS_START_HI = 6'd33;
    localparam logic [POS_W-1:0] POS_QTY_LO   = 6'd34;
    localparam logic [POS_W-1:0] POS_QTY_HI   = 6'd35;
    localparam logic [POS_W-1:0] POS_CRC_LO   = 6'd36;
    localparam logic [POS_W-1:0] POS_LAST     = 6'd37;

    localparam logic [BYTE_W-1:0] DATA_LEN_LO = 8'h12;
    localparam logic [BYTE_W-1:0] DATA_LEN_HI = 8'h00;
    localparam logic [BYTE_W-1:0] ACTION_CODE = 8'h01;
    localparam logic [BYTE_W-1:0] FUNC_CODE   = 8'h04;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] QTY_RESET = 16'd40;

    localparam logic [BYTE_W-1:0] HEADER [8] = '{
        8'hA1, 8'h1A, 8'h02, 8'h00, 8'h20, 8'h00, 8'h01, 8'hC2
    };

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DONGLE_LO = 3'd0,
        REG_DONGLE_HI = 3'd1,
        REG_SERIAL_LO = 3'd2,
        REG_SERIAL_HI = 3'd3,
        REG_QUANTITY  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [79:0] dev_ident;
        logic [79:0] serial;
        logic [15:0] quantity;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] start;
    } t_req_head;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] v;
        v = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] frame_byte(
        input logic [POS_W-1:0]   pos,
        input t_cfg               cfg,
        input logic [START_W-1:0] start,
        input logic [15:0]        crc
    );
        logic [3:0] dix;
        logic [3:0] six;
        logic [BYTE_W-1:0] b;
        dix = 4'(pos - POS_DONGLE);
        six = 4'(pos - POS_SERIAL);
        if (pos < POS_DONGLE) begin
            b = HEADER[pos[2:0]];
        end else if (pos < POS_LEN_LO) begin
            b = cfg.dev_ident[dix*8 +: 8];
        end else if (pos == POS_LEN_LO) begin
            b = DATA_LEN_LO;
        end else if (pos == POS_LEN_HI) begin
            b = DATA_LEN_HI;
        end else if (pos == POS_ACTION) begin
            b = ACTION_CODE;
        end else if (pos == POS_FUNC) begin
            b = FUNC_CODE;
        end else if (pos < POS_START_LO) begin
            b = cfg.serial[six*8 +: 8];
        end else if (pos == POS_START_LO) begin
            b = start[7:0];
        end else if (pos == POS_START_HI) begin
            b = start[15:8];
        end else if (pos == POS_QTY_LO) begin
            b = cfg.quantity[7:0];
        end else if (pos == POS_QTY_HI) begin
            b = cfg.quantity[15:8];
        end else if (pos == POS_CRC_LO) begin
            b = crc[7:0];
        end else begin
            b = crc[15:8];
        end
        return b;
    endfunction

endpackage

>>> rtl/core/read_request_frame_builder_unit.sv
// top level: configuration registers, request queue and frame serializer
// depends on rrfb_pkg, rrfb_queue, rrfb_back
// a frame's first byte is registered at the output after its request word enters the queue
// one frame byte per cycle while the sink is ready, set by the serializer
// frames follow back to back with no gap; one further request can wait behind the active one
// reset: synchronous active low, clears queue and serializer, registers to defaults

module read_request_frame_builder_unit
    import rrfb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,    // start_register[15:0]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,    // frame_byte[7:0], byte_position[13:8], zero pad
    output logic                  o_m_tlast,    // last_byte
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_req_head head;
    logic      pop;
    logic      cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_ident <= '0;
            r_cfg.serial    <= '0;
            r_cfg.quantity  <= QTY_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_DONGLE_LO: r_cfg.dev_ident[63:0]  <= i_cfg_data;
                REG_DONGLE_HI: r_cfg.dev_ident[79:64] <= i_cfg_data[15:0];
                REG_SERIAL_LO: r_cfg.serial[63:0]     <= i_cfg_data;
                REG_SERIAL_HI: r_cfg.serial[79:64]    <= i_cfg_data[15:0];
                REG_QUANTITY:  r_cfg.quantity         <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    rrfb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_head     (head),
        .i_pop      (pop)
    );

    rrfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg      (r_cfg),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

>>> rtl/core/rrfb_queue.sv
// front part: accepts request words into a two-entry queue
// depends on rrfb_pkg

module rrfb_queue
    import rrfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [START_W-1:0] i_s_tdata,   // start_register
    output t_req_head          o_head,
    input  logic               i_pop
);

    logic [START_W-1:0] r_mem [2];
    logic               r_wr_ptr, n_wr_ptr;
    logic               r_rd_ptr, n_rd_ptr;
    logic [1:0]         r_count,  n_count;
    logic               push;

    assign o_s_tready   = (r_count != 2'd2);
    assign push         = i_s_tvalid && o_s_tready;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.start = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_s_tdata;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count overflow");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step");

endmodule

>>> rtl/core/rrfb_back.sv
// back part: serializes one frame per queued request with running crc
// depends on rrfb_pkg

module rrfb_back
    import rrfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req_head   i_head,
    output logic        o_pop,
    input  t_cfg        i_cfg,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // frame_byte[7:0], byte_position[13:8], zero pad
    output logic        o_m_tlast    // last_byte
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_last;
    logic              slot_free, load, is_last, in_crc;
    logic [BYTE_W-1:0] cur_byte;

    assign slot_free = !r_out_valid || i_m_tready;
    assign load      = slot_free && i_head.valid;
    assign is_last   = (r_pos == POS_LAST);
    assign in_crc    = (r_pos >= POS_ACTION) && (r_pos <= POS_QTY_HI);
    assign cur_byte  = frame_byte(r_pos, i_cfg, i_head.start, r_crc);
    assign o_pop     = load && is_last;

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        if (load) begin
            n_pos = is_last ? '0 : r_pos + 6'd1;
            if (is_last) begin
                n_crc = CRC_INIT;
            end else if (in_crc) begin
                n_crc = crc16_byte(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_out_valid <= load || (r_out_valid && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_pos  <= r_pos;
            r_out_last <= is_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_pos, r_out_byte};
    assign o_m_tlast  = r_out_last;

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (r_out_pos == POS_LAST))
        else $error("last flag off final position");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
        (o_m_tvalid && r_out_pos == $past(r_out_pos) + 6'd1))
        else $error("frame byte not followed by next position");
    a_crc_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_crc == CRC_INIT && r_pos == '0))
        else $error("crc or position not rearmed after frame");

endmodule
